// ===== src/gsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and register codes of the gas sensor ppm converter.
package gsp_pkg;

  localparam int CAL_SAMPLES    = 50;
  localparam int MEAS_SAMPLES   = 5;
  localparam int ADC_FULL_SCALE = 1023;

  localparam int CNT_W = 6;
  localparam int SUM_W = 30;
  localparam int ADC_W = 10;
  localparam int RES_W = 24;
  localparam int PPM_W = 20;

  localparam logic [RES_W-1:0] MAX24  = 24'hFFFFFF;
  localparam logic [PPM_W-1:0] MAXPPM = 20'hFFFFF;

  localparam logic [18:0] LOG10_2_Q20 = 19'd315653;
  localparam logic [17:0] LOG2_10_Q16 = 18'd217706;
  localparam logic [39:0] T_LIMIT     = 40'd458752;

  // divider geometry
  localparam int DIV_NW = 38;
  localparam int DIV_DW = 24;
  localparam int DIV_CW = 6;

  // register indexes
  localparam logic [2:0] REG_LOAD_RES  = 3'd0;
  localparam logic [2:0] REG_CLEAN_AIR = 3'd1;
  localparam logic [2:0] REG_LPG_X     = 3'd2;
  localparam logic [2:0] REG_LPG_Y     = 3'd3;
  localparam logic [2:0] REG_LPG_SLOPE = 3'd4;
  localparam logic [2:0] REG_SMK_X     = 3'd5;
  localparam logic [2:0] REG_SMK_Y     = 3'd6;
  localparam logic [2:0] REG_SMK_SLOPE = 3'd7;

  localparam logic [15:0] RST_LOAD_RES  = 16'd1280;
  localparam logic [15:0] RST_CLEAN_AIR = 16'd2516;
  localparam logic [15:0] RST_LPG_X     = 16'd9421;
  localparam logic [15:0] RST_LPG_Y     = 16'd819;
  localparam logic [15:0] RST_LPG_SLOPE = 16'hF8CD;
  localparam logic [15:0] RST_SMK_X     = 16'd9421;
  localparam logic [15:0] RST_SMK_Y     = 16'd2171;
  localparam logic [15:0] RST_SMK_SLOPE = 16'hF91F;

  typedef struct packed {
    logic             cmd;
    logic [ADC_W-1:0] adc_sample;
    logic [1:0]       gas_select;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [RES_W-1:0] resistance;
    logic [RES_W-1:0] ratio;
    logic [PPM_W-1:0] ppm;
    logic             fault;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] numer;
    logic [DIV_DW-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_resp_t;

endpackage

// ===== src/gas_sensor_ppm_converter.sv =====
`timescale 1ns / 1ps
// Top level of the gas sensor ppm converter: sequencer, shared multiplier, registers.
// Converts tagged 10-bit ADC samples into sensor resistance, averages batches of
// calibration or measurement samples and reports the reference resistance or the
// resistance, ratio and ppm of the selected log-log curve. One item is in work at a
// time; in_stall is high while it runs. A sample that does not end a batch takes
// one 38-step divide for the resistance; a zero or full-scale sample skips the
// divide. A sample that ends a calibration batch adds two divides. One that ends a
// measurement batch adds two divides, 16 squarings for the log, a signed divide and
// 16 bit-serial square roots of 32 steps each, plus one multiply for each set
// exponent bit, for the power. A result waits in the output register while the
// next item is taken.
module gas_sensor_ppm_converter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gsp_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gsp_pkg::out_item_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import gsp_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RMUL = 5'd1;
  localparam logic [4:0] S_RDIV = 5'd2;
  localparam logic [4:0] S_ACC  = 5'd3;
  localparam logic [4:0] S_AVG  = 5'd4;
  localparam logic [4:0] S_CDIV = 5'd5;
  localparam logic [4:0] S_MDIV = 5'd6;
  localparam logic [4:0] S_CONC = 5'd7;
  localparam logic [4:0] S_LSQ  = 5'd8;
  localparam logic [4:0] S_LMUL = 5'd9;
  localparam logic [4:0] S_LRND = 5'd10;
  localparam logic [4:0] S_QDIV = 5'd11;
  localparam logic [4:0] S_PMUL = 5'd12;
  localparam logic [4:0] S_SQRT = 5'd13;
  localparam logic [4:0] S_PACC = 5'd14;
  localparam logic [4:0] S_PFIN = 5'd15;
  localparam logic [4:0] S_FIN  = 5'd16;

  function automatic logic [RES_W-1:0] sat24(input logic [DIV_NW-1:0] v);
    return (v > DIV_NW'(MAX24)) ? MAX24 : v[RES_W-1:0];
  endfunction

  // configuration
  logic [15:0] rl_r, caf_r, lx_r, ly_r, ls_r, sx_r, sy_r, ss_r;

  logic [4:0]       state_r, state_nxt;
  logic             cmd_r, cmd_nxt;
  logic [ADC_W-1:0] adc_r, adc_nxt;
  logic [1:0]       gas_r, gas_nxt;
  logic             mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             fs_r, fs_nxt;
  logic [RES_W-1:0] r0_r, r0_nxt;
  logic             f_r, f_nxt;
  logic [RES_W-1:0] res_r, res_nxt;
  logic [RES_W-1:0] ratio_r, ratio_nxt;
  logic [PPM_W-1:0] ppm_r, ppm_nxt;
  logic [4:0]       p_r, p_nxt;
  logic [30:0]      x_r, x_nxt;
  logic [15:0]      frac_r, frac_nxt;
  logic [3:0]       it_r, it_nxt;
  logic             lneg_r, lneg_nxt;
  logic [39:0]      lprod_r, lprod_nxt;
  logic             qneg_r, qneg_nxt;
  logic [39:0]      t_r, t_nxt;
  logic [20:0]      u_r, u_nxt;
  logic [31:0]      rr_r, rr_nxt;
  logic [30:0]      acc_r, acc_nxt;
  logic [4:0]       k_r, k_nxt;
  logic [61:0]      sqn_r, sqn_nxt;
  logic [62:0]      sqr_r, sqr_nxt;
  logic [4:0]       sqj_r, sqj_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  // shared multiplier and divider
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  div_req_t    div_req;
  div_resp_t   div_resp;

  // working values
  logic             in_acc;
  logic [15:0]      cx, cy, cs, smag;
  logic [SUM_W-1:0] sum_inc, avg;
  logic [CNT_W-1:0] cnt_inc, need_cur, need_mode;
  logic [4:0]       msb, pm8, kidx;
  logic [31:0]      sq;
  logic [20:0]      l2, l2mag;
  logic [19:0]      lgmag;
  logic [22:0]      lg, ys, dd, dmag;
  logic [39:0]      qv, xs, tv;
  logic [62:0]      bb;
  logic [63:0]      rb;
  logic [62:0]      sq_new;
  logic [31:0]      rk;
  logic [53:0]      pw;

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  gsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .resp  (div_resp)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    msb = '0;
    for (int i = 0; i < RES_W; i++) begin
      if (ratio_r[i]) msb = 5'(i);
    end
  end

  assign need_mode = mode_r ? CNT_W'(MEAS_SAMPLES) : CNT_W'(CAL_SAMPLES);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    adc_nxt       = adc_r;
    gas_nxt       = gas_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    fs_nxt        = fs_r;
    r0_nxt        = r0_r;
    f_nxt         = f_r;
    res_nxt       = res_r;
    ratio_nxt     = ratio_r;
    ppm_nxt       = ppm_r;
    p_nxt         = p_r;
    x_nxt         = x_r;
    frac_nxt      = frac_r;
    it_nxt        = it_r;
    lneg_nxt      = lneg_r;
    lprod_nxt     = lprod_r;
    qneg_nxt      = qneg_r;
    t_nxt         = t_r;
    u_nxt         = u_r;
    rr_nxt        = rr_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    sqn_nxt       = sqn_r;
    sqr_nxt       = sqr_r;
    sqj_nxt       = sqj_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_req       = '0;
    mul_a         = '0;
    mul_b         = '0;

    cx       = gas_r[0] ? sx_r : lx_r;
    cy       = gas_r[0] ? sy_r : ly_r;
    cs       = gas_r[0] ? ss_r : ls_r;
    smag     = cs[15] ? (~cs + 16'd1) : cs;
    sum_inc  = sum_r + SUM_W'(res_r);
    cnt_inc  = cnt_r + 1'b1;
    need_cur = cmd_r ? CNT_W'(MEAS_SAMPLES) : CNT_W'(CAL_SAMPLES);
    avg      = div_resp.quot[SUM_W-1:0];
    sq       = mul_p[61:30];
    pm8      = p_r - 5'd8;
    l2       = {pm8, frac_r};
    l2mag    = pm8[4] ? (~l2 + 21'd1) : l2;
    lgmag    = 20'((lprod_r + 40'd524288) >> 20);
    lg       = lneg_r ? (~{3'b000, lgmag} + 23'd1) : {3'b000, lgmag};
    ys       = {{3{cy[15]}}, cy, 4'b0000};
    dd       = lg - ys;
    dmag     = dd[22] ? (~dd + 23'd1) : dd;
    qv       = qneg_r ? (~{2'b00, div_resp.quot} + 40'd1) : {2'b00, div_resp.quot};
    xs       = {{20{cx[15]}}, cx, 4'b0000};
    tv       = qv + xs;
    bb       = 63'(1) << {sqj_r, 1'b0};
    rb       = {1'b0, sqr_r} + {1'b0, bb};
    sq_new   = ({2'b00, sqn_r} >= rb) ? ((sqr_r >> 1) + bb) : (sqr_r >> 1);
    rk       = sq_new[31:0];
    kidx     = 5'd16 - k_r;
    pw       = {23'b0, acc_r} << u_r[20:16];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_data.cmd;
          adc_nxt = in_data.adc_sample;
          gas_nxt = in_data.gas_select;
          // a change of mode drops the partial batch
          if (in_data.cmd != mode_r) begin
            mode_nxt = in_data.cmd;
            cnt_nxt  = '0;
            sum_nxt  = '0;
            fs_nxt   = 1'b0;
          end
          if (in_data.adc_sample == '0) begin
            res_nxt   = MAX24;
            fs_nxt    = 1'b1;
            state_nxt = S_ACC;
          end else if (in_data.adc_sample >= ADC_W'(ADC_FULL_SCALE)) begin
            res_nxt   = '0;
            state_nxt = S_ACC;
          end else begin
            state_nxt = S_RMUL;
          end
        end
      end
      S_RMUL: begin
        mul_a         = {16'b0, rl_r};
        mul_b         = {22'b0, ADC_W'(ADC_FULL_SCALE) - adc_r};
        div_req.start = 1'b1;
        div_req.numer = mul_p[DIV_NW-1:0];
        div_req.denom = DIV_DW'(adc_r);
        state_nxt     = S_RDIV;
      end
      S_RDIV: begin
        if (div_resp.done) begin
          res_nxt   = sat24(div_resp.quot);
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (cnt_inc < need_cur) begin
          sum_nxt   = sum_inc;
          cnt_nxt   = cnt_inc;
          state_nxt = S_IDLE;
        end else begin
          div_req.start = 1'b1;
          div_req.numer = DIV_NW'(sum_inc);
          div_req.denom = DIV_DW'(need_cur);
          f_nxt         = fs_r;
          ratio_nxt     = '0;
          ppm_nxt       = '0;
          cnt_nxt       = '0;
          sum_nxt       = '0;
          fs_nxt        = 1'b0;
          state_nxt     = S_AVG;
        end
      end
      S_AVG: begin
        if (div_resp.done) begin
          if (!cmd_r) begin
            if (caf_r == '0) begin
              f_nxt     = 1'b1;
              res_nxt   = MAX24;
              r0_nxt    = MAX24;
              state_nxt = S_FIN;
            end else begin
              div_req.start = 1'b1;
              div_req.numer = {avg, 8'b0};
              div_req.denom = DIV_DW'(caf_r);
              state_nxt     = S_CDIV;
            end
          end else begin
            res_nxt = avg[RES_W-1:0];
            if (r0_r == '0) begin
              f_nxt     = 1'b1;
              ratio_nxt = MAX24;
              state_nxt = S_CONC;
            end else begin
              div_req.start = 1'b1;
              div_req.numer = {avg, 8'b0};
              div_req.denom = r0_r;
              state_nxt     = S_MDIV;
            end
          end
        end
      end
      S_CDIV: begin
        if (div_resp.done) begin
          res_nxt   = sat24(div_resp.quot);
          r0_nxt    = sat24(div_resp.quot);
          state_nxt = S_FIN;
        end
      end
      S_MDIV: begin
        if (div_resp.done) begin
          ratio_nxt = sat24(div_resp.quot);
          state_nxt = S_CONC;
        end
      end
      S_CONC: begin
        if (gas_r[1]) begin
          ppm_nxt   = '0;
          state_nxt = S_FIN;
        end else if (cs == '0) begin
          f_nxt     = 1'b1;
          ppm_nxt   = MAXPPM;
          state_nxt = S_FIN;
        end else if (ratio_r == '0) begin
          ppm_nxt   = cs[15] ? MAXPPM : '0;
          state_nxt = S_FIN;
        end else begin
          // mantissa normalized to [1,2) in Q30
          x_nxt     = {7'b0, ratio_r} << (5'd30 - msb);
          p_nxt     = msb;
          frac_nxt  = '0;
          it_nxt    = '0;
          state_nxt = S_LSQ;
        end
      end
      S_LSQ: begin
        mul_a = {1'b0, x_r};
        mul_b = {1'b0, x_r};
        if (sq[31]) begin
          x_nxt    = sq[31:1];
          frac_nxt = {frac_r[14:0], 1'b1};
        end else begin
          x_nxt    = sq[30:0];
          frac_nxt = {frac_r[14:0], 1'b0};
        end
        it_nxt = it_r + 1'b1;
        if (it_r == 4'd15) state_nxt = S_LMUL;
      end
      S_LMUL: begin
        // sign and magnitude so the rounding goes half away from zero
        mul_a     = {11'b0, l2mag};
        mul_b     = {13'b0, LOG10_2_Q20};
        lprod_nxt = mul_p[39:0];
        lneg_nxt  = pm8[4];
        state_nxt = S_LRND;
      end
      S_LRND: begin
        div_req.start = 1'b1;
        div_req.numer = {4'b0, dmag[21:0], 12'b0};
        div_req.denom = DIV_DW'(smag);
        qneg_nxt      = dd[22] ^ cs[15];
        state_nxt     = S_QDIV;
      end
      S_QDIV: begin
        if (div_resp.done) begin
          if (tv[39]) begin
            ppm_nxt   = '0;
            state_nxt = S_FIN;
          end else if (tv >= T_LIMIT) begin
            ppm_nxt   = MAXPPM;
            state_nxt = S_FIN;
          end else begin
            t_nxt     = tv;
            state_nxt = S_PMUL;
          end
        end
      end
      S_PMUL: begin
        mul_a     = {13'b0, t_r[18:0]};
        mul_b     = {14'b0, LOG2_10_Q16};
        u_nxt     = mul_p[36:16];
        rr_nxt    = 32'h8000_0000;
        acc_nxt   = 31'h4000_0000;
        k_nxt     = 5'd1;
        sqn_nxt   = {32'h8000_0000, 30'b0};
        sqr_nxt   = '0;
        sqj_nxt   = 5'd31;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if ({2'b00, sqn_r} >= rb) sqn_nxt = 62'({2'b00, sqn_r} - rb);
        sqr_nxt = sq_new;
        sqj_nxt = sqj_r - 1'b1;
        if (sqj_r == '0) begin
          rr_nxt = rk;
          if (u_r[kidx[3:0]]) begin
            state_nxt = S_PACC;
          end else if (k_r == 5'd16) begin
            state_nxt = S_PFIN;
          end else begin
            k_nxt   = k_r + 1'b1;
            sqn_nxt = {rk, 30'b0};
            sqr_nxt = '0;
            sqj_nxt = 5'd31;
          end
        end
      end
      S_PACC: begin
        mul_a   = {1'b0, acc_r};
        mul_b   = rr_r;
        acc_nxt = mul_p[60:30];
        if (k_r == 5'd16) begin
          state_nxt = S_PFIN;
        end else begin
          k_nxt     = k_r + 1'b1;
          sqn_nxt   = {rr_r, 30'b0};
          sqr_nxt   = '0;
          sqj_nxt   = 5'd31;
          state_nxt = S_SQRT;
        end
      end
      S_PFIN: begin
        ppm_nxt   = (pw[53:30] > RES_W'(MAXPPM)) ? MAXPPM : pw[49:30];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.kind       = cmd_r;
          out_data_nxt.resistance = res_r;
          out_data_nxt.ratio      = ratio_r;
          out_data_nxt.ppm        = ppm_r;
          out_data_nxt.fault      = f_r;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b0;
      cnt_r       <= '0;
      sum_r       <= '0;
      fs_r        <= 1'b0;
      r0_r        <= '0;
      out_valid_r <= 1'b0;
      rl_r        <= RST_LOAD_RES;
      caf_r       <= RST_CLEAN_AIR;
      lx_r        <= RST_LPG_X;
      ly_r        <= RST_LPG_Y;
      ls_r        <= RST_LPG_SLOPE;
      sx_r        <= RST_SMK_X;
      sy_r        <= RST_SMK_Y;
      ss_r        <= RST_SMK_SLOPE;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      fs_r        <= fs_nxt;
      r0_r        <= r0_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite) begin
        unique case (paddr[4:2])
          REG_LOAD_RES:  rl_r  <= pwdata[15:0];
          REG_CLEAN_AIR: caf_r <= pwdata[15:0];
          REG_LPG_X:     lx_r  <= pwdata[15:0];
          REG_LPG_Y:     ly_r  <= pwdata[15:0];
          REG_LPG_SLOPE: ls_r  <= pwdata[15:0];
          REG_SMK_X:     sx_r  <= pwdata[15:0];
          REG_SMK_Y:     sy_r  <= pwdata[15:0];
          REG_SMK_SLOPE: ss_r  <= pwdata[15:0];
          default:       rl_r  <= rl_r;
        endcase
      end
    end
    cmd_r      <= cmd_nxt;
    adc_r      <= adc_nxt;
    gas_r      <= gas_nxt;
    f_r        <= f_nxt;
    res_r      <= res_nxt;
    ratio_r    <= ratio_nxt;
    ppm_r      <= ppm_nxt;
    p_r        <= p_nxt;
    x_r        <= x_nxt;
    frac_r     <= frac_nxt;
    it_r       <= it_nxt;
    lneg_r     <= lneg_nxt;
    lprod_r    <= lprod_nxt;
    qneg_r     <= qneg_nxt;
    t_r        <= t_nxt;
    u_r        <= u_nxt;
    rr_r       <= rr_nxt;
    acc_r      <= acc_nxt;
    k_r        <= k_nxt;
    sqn_r      <= sqn_nxt;
    sqr_r      <= sqr_nxt;
    sqj_r      <= sqj_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_LOAD_RES:  prdata = {16'b0, rl_r};
      REG_CLEAN_AIR: prdata = {16'b0, caf_r};
      REG_LPG_X:     prdata = {16'b0, lx_r};
      REG_LPG_Y:     prdata = {16'b0, ly_r};
      REG_LPG_SLOPE: prdata = {16'b0, ls_r};
      REG_SMK_X:     prdata = {16'b0, sx_r};
      REG_SMK_Y:     prdata = {16'b0, sy_r};
      REG_SMK_SLOPE: prdata = {16'b0, ss_r};
      default:       prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_resp.busy)
    else $error("divider started while busy");

  a_count_below_need: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r < need_mode))
    else $error("batch count reached its size without a result");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside the finish step");

  a_cal_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.kind) |-> (out_data_r.ratio == '0 && out_data_r.ppm == '0))
    else $error("calibration result carries ratio or ppm");

endmodule

// ===== src/gsp_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module gsp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gsp_pkg::div_req_t  req,
  output gsp_pkg::div_resp_t resp
);
  import gsp_pkg::*;

  logic [DIV_NW-1:0] q_r, q_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW+1:0] diff;

  always_comb begin
    shifted  = {rem_r, q_r[DIV_NW-1]};
    diff     = {1'b0, shifted} - {2'b00, den_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt    = req.numer;
      rem_nxt  = '0;
      den_nxt  = req.denom;
      cnt_nxt  = DIV_CW'(DIV_NW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (diff[DIV_DW+1]) begin
        rem_nxt = shifted[DIV_DW-1:0];
        q_nxt   = {q_r[DIV_NW-2:0], 1'b0};
      end else begin
        rem_nxt = diff[DIV_DW-1:0];
        q_nxt   = {q_r[DIV_NW-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign resp.busy = busy_r;
  assign resp.done = done_r;
  assign resp.quot = q_r;

endmodule
